>>> rtl/core/esctp_pkg.sv
// Shared types, constants and character helpers for the ESC telemetry text parser.
package esctp_pkg;

    // Default depth of the received byte history
    localparam int HISTORY_LEN_DEF = 10;

    // Widths of the result fields
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 16;

    // Message kinds, in header priority order
    typedef enum logic [KIND_W-1:0] {
        KIND_SPEED       = 3'd0,
        KIND_MOSFET_TEMP = 3'd1,
        KIND_MOTOR_TEMP  = 3'd2,
        KIND_CURRENT     = 3'd3,
        KIND_VOLTAGE     = 3'd4,
        KIND_NONE        = 3'd5
    } t_msg_kind;

    // ASCII characters used by the framing
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_V      = 8'h56;

    // Uppercase hex digit check
    function automatic logic is_hex_digit(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
    endfunction

    // Nibble value of a valid uppercase hex digit
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c <= CH_9) begin
            d = c - CH_0;
        end else begin
            d = c - CH_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

>>> rtl/core/esc_telemetry_text_parser.sv
// Top level of the ESC telemetry text parser: byte history, header match and readings.
//
// Usage:
//   Input channel: one received UART character per item on i_rx_byte, offered
//   with i_valid and held off by o_stall. Output channel: one result item per
//   input item on o_msg_kind, o_msg_value and the five reading ports, offered
//   with o_valid and held off by i_stall.
//   Each byte shifts into a history of the last HISTORY_LEN bytes. On a space,
//   the bytes before it are matched against SPD:, TMOS:, TMOT:, CURI: and
//   VOLT: (first match wins) followed by four uppercase hex digits; a match
//   updates that reading. Current and voltage are raw counts of 0.01 units.
//   Latency: the result of a byte is shown the cycle after it is accepted.
//   Throughput: one byte per cycle while o_stall is low; the parallel compares
//   and the single result register set this figure, and a new byte is taken
//   while the last result is being taken by the receiver.
//   Stall: while a result waits under i_stall, o_stall is raised and the
//   result and readings hold.
//   Reset (synchronous, active low): the history fills with '.' characters,
//   all readings clear to zero and no result is offered.
module esc_telemetry_text_parser #(
    parameter int HISTORY_LEN = esctp_pkg::HISTORY_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [esctp_pkg::KIND_W-1:0]  o_msg_kind,
    output logic [esctp_pkg::VALUE_W-1:0] o_msg_value,
    output logic [esctp_pkg::VALUE_W-1:0] o_speed_reading,
    output logic [esctp_pkg::VALUE_W-1:0] o_mosfet_temp_reading,
    output logic [esctp_pkg::VALUE_W-1:0] o_motor_temp_reading,
    output logic [esctp_pkg::VALUE_W-1:0] o_current_reading,
    output logic [esctp_pkg::VALUE_W-1:0] o_voltage_reading
);

    // Positions in the history before the shift; newest byte at HISTORY_LEN-1.
    // After the shift the space sits at the end, the digits just before it.
    localparam int DIG0 = HISTORY_LEN - 4;  // most significant digit
    localparam int SPD0 = HISTORY_LEN - 8;  // 'S' of SPD:
    localparam int HDR0 = HISTORY_LEN - 9;  // first char of five-byte headers

    logic [7:0] r_hist [HISTORY_LEN];

    logic [esctp_pkg::VALUE_W-1:0] r_speed, r_mosfet, r_motor, r_current, r_voltage;

    logic                          r_out_valid;
    esctp_pkg::t_msg_kind          r_kind;
    logic [esctp_pkg::VALUE_W-1:0] r_value;

    logic                          accept;
    logic                          digits_ok;
    logic                          m_spd, m_tmos, m_tmot, m_curi, m_volt;
    esctp_pkg::t_msg_kind          n_kind;
    logic [esctp_pkg::VALUE_W-1:0] dec_value;
    logic [esctp_pkg::VALUE_W-1:0] n_value;

    // Handshake
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // Digit check and decode on the four bytes before the space
    always_comb begin
        digits_ok = 1'b1;
        dec_value = '0;
        for (int k = 0; k < 4; k++) begin
            digits_ok = digits_ok & esctp_pkg::is_hex_digit(r_hist[DIG0 + k]);
            dec_value = {dec_value[esctp_pkg::VALUE_W-5:0],
                         esctp_pkg::hex_nibble(r_hist[DIG0 + k])};
        end
    end

    // Header compares at fixed positions
    assign m_spd  = (r_hist[SPD0]     == esctp_pkg::CH_S) &&
                    (r_hist[SPD0 + 1] == esctp_pkg::CH_P) &&
                    (r_hist[SPD0 + 2] == esctp_pkg::CH_D) &&
                    (r_hist[SPD0 + 3] == esctp_pkg::CH_COLON);
    assign m_tmos = (r_hist[HDR0]     == esctp_pkg::CH_T) &&
                    (r_hist[HDR0 + 1] == esctp_pkg::CH_M) &&
                    (r_hist[HDR0 + 2] == esctp_pkg::CH_O) &&
                    (r_hist[HDR0 + 3] == esctp_pkg::CH_S) &&
                    (r_hist[HDR0 + 4] == esctp_pkg::CH_COLON);
    assign m_tmot = (r_hist[HDR0]     == esctp_pkg::CH_T) &&
                    (r_hist[HDR0 + 1] == esctp_pkg::CH_M) &&
                    (r_hist[HDR0 + 2] == esctp_pkg::CH_O) &&
                    (r_hist[HDR0 + 3] == esctp_pkg::CH_T) &&
                    (r_hist[HDR0 + 4] == esctp_pkg::CH_COLON);
    assign m_curi = (r_hist[HDR0]     == esctp_pkg::CH_C) &&
                    (r_hist[HDR0 + 1] == esctp_pkg::CH_U) &&
                    (r_hist[HDR0 + 2] == esctp_pkg::CH_R) &&
                    (r_hist[HDR0 + 3] == esctp_pkg::CH_I) &&
                    (r_hist[HDR0 + 4] == esctp_pkg::CH_COLON);
    assign m_volt = (r_hist[HDR0]     == esctp_pkg::CH_V) &&
                    (r_hist[HDR0 + 1] == esctp_pkg::CH_O) &&
                    (r_hist[HDR0 + 2] == esctp_pkg::CH_L) &&
                    (r_hist[HDR0 + 3] == esctp_pkg::CH_T) &&
                    (r_hist[HDR0 + 4] == esctp_pkg::CH_COLON);

    // Message kind, first header in priority order wins
    always_comb begin
        n_kind = esctp_pkg::KIND_NONE;
        if ((i_rx_byte == esctp_pkg::CH_SPACE) && digits_ok) begin
            priority if (m_spd)  n_kind = esctp_pkg::KIND_SPEED;
            else if (m_tmos)     n_kind = esctp_pkg::KIND_MOSFET_TEMP;
            else if (m_tmot)     n_kind = esctp_pkg::KIND_MOTOR_TEMP;
            else if (m_curi)     n_kind = esctp_pkg::KIND_CURRENT;
            else if (m_volt)     n_kind = esctp_pkg::KIND_VOLTAGE;
            else                 n_kind = esctp_pkg::KIND_NONE;
        end
        n_value = (n_kind == esctp_pkg::KIND_NONE) ? '0 : dec_value;
    end

    // Byte history shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_LEN; k++) begin
                r_hist[k] <= esctp_pkg::CH_PERIOD;
            end
        end else if (accept) begin
            for (int k = 0; k < HISTORY_LEN - 1; k++) begin
                r_hist[k] <= r_hist[k + 1];
            end
            r_hist[HISTORY_LEN - 1] <= i_rx_byte;
        end
    end

    // Reading stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_mosfet  <= '0;
            r_motor   <= '0;
            r_current <= '0;
            r_voltage <= '0;
        end else if (accept) begin
            unique case (n_kind)
                esctp_pkg::KIND_SPEED:       r_speed   <= dec_value;
                esctp_pkg::KIND_MOSFET_TEMP: r_mosfet  <= dec_value;
                esctp_pkg::KIND_MOTOR_TEMP:  r_motor   <= dec_value;
                esctp_pkg::KIND_CURRENT:     r_current <= dec_value;
                esctp_pkg::KIND_VOLTAGE:     r_voltage <= dec_value;
                default: ;
            endcase
        end
    end

    // Result register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= n_kind;
            r_value <= n_value;
        end
    end

    // Outputs; stores only move on accept, so they match the item shown
    assign o_valid               = r_out_valid;
    assign o_msg_kind            = r_kind;
    assign o_msg_value           = r_value;
    assign o_speed_reading       = r_speed;
    assign o_mosfet_temp_reading = r_mosfet;
    assign o_motor_temp_reading  = r_motor;
    assign o_current_reading     = r_current;
    assign o_voltage_reading     = r_voltage;

endmodule
